>>> rtl/core/sps_pkg.sv
// Shared types, codes and helper functions of the SPS header parser.
package sps_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOT_SPS = 2'd1;
    localparam logic [1:0] STAT_EARLY   = 2'd2;
    localparam logic [1:0] STAT_LONG    = 2'd3;

    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [7:0] EPB_BYTE     = 8'h03;

    // syntax steps
    localparam logic [6:0] ST_HDR          = 7'd0;
    localparam logic [6:0] ST_PROFILE      = 7'd1;
    localparam logic [6:0] ST_HIGH         = 7'd4;
    localparam logic [6:0] ST_CHROMA       = 7'd5;
    localparam logic [6:0] ST_SEP_PLANE    = 7'd6;
    localparam logic [6:0] ST_BITDEPTH     = 7'd7;
    localparam logic [6:0] ST_TRANS_BYPASS = 7'd9;
    localparam logic [6:0] ST_SCALE_FLAG   = 7'd10;
    localparam logic [6:0] ST_LIST_FLAG    = 7'd11;
    localparam logic [6:0] ST_DELTA        = 7'd12;
    localparam logic [6:0] ST_LOG2_FRAME   = 7'd13;
    localparam logic [6:0] ST_POC_TYPE     = 7'd14;
    localparam logic [6:0] ST_POC_LSB      = 7'd15;
    localparam logic [6:0] ST_POC_DZERO    = 7'd16;
    localparam logic [6:0] ST_POC_NREF     = 7'd19;
    localparam logic [6:0] ST_POC_OFFSET   = 7'd20;
    localparam logic [6:0] ST_NUM_REF      = 7'd21;
    localparam logic [6:0] ST_GAPS         = 7'd22;
    localparam logic [6:0] ST_WIDTH        = 7'd23;
    localparam logic [6:0] ST_HEIGHT       = 7'd24;
    localparam logic [6:0] ST_MBS_ONLY     = 7'd25;
    localparam logic [6:0] ST_ADAPT        = 7'd26;
    localparam logic [6:0] ST_DIRECT8      = 7'd27;
    localparam logic [6:0] ST_CROP         = 7'd28;
    localparam logic [6:0] ST_CROP_L       = 7'd29;
    localparam logic [6:0] ST_VUI          = 7'd33;
    localparam logic [6:0] ST_AR_FLAG      = 7'd34;
    localparam logic [6:0] ST_AR_IDC       = 7'd35;
    localparam logic [6:0] ST_SAR          = 7'd36;
    localparam logic [6:0] ST_OVERSCAN     = 7'd37;
    localparam logic [6:0] ST_OVERSCAN_APP = 7'd38;
    localparam logic [6:0] ST_VSIG         = 7'd39;
    localparam logic [6:0] ST_VFMT         = 7'd40;
    localparam logic [6:0] ST_COLOR        = 7'd41;
    localparam logic [6:0] ST_CHROMA_LOC   = 7'd42;
    localparam logic [6:0] ST_CHROMA_TOP   = 7'd43;
    localparam logic [6:0] ST_TIMING       = 7'd45;
    localparam logic [6:0] ST_TICK         = 7'd46;
    localparam logic [6:0] ST_TSCALE       = 7'd47;
    localparam logic [6:0] ST_DONE         = 7'd48;

    localparam logic [7:0] AR_EXTENDED  = 8'd255;
    localparam logic [7:0] SCALE_INIT   = 8'd8;
    localparam logic [7:0] PROF_HIGH    = 8'd100;
    localparam logic [7:0] PROF_HIGH10  = 8'd110;
    localparam logic [7:0] PROF_HIGH422 = 8'd122;
    localparam logic [7:0] PROF_HIGH444 = 8'd144;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic       last_byte;
        logic       drop;
    } t_entry;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  profile;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic        frame_mbs_only;
        logic        timing_present;
        logic [31:0] units_in_tick;
        logic [31:0] units_per_sec;
    } t_result;

    // fixed-length field width of a step, zero for Exp-Golomb steps
    function automatic logic [5:0] read_bits(input logic [6:0] s);
        logic [5:0] n;
        case (s) inside
            7'd1, 7'd2, 7'd3, 7'd35:                          n = 6'd8;
            7'd6, 7'd9, 7'd10, 7'd11, 7'd16, 7'd22, 7'd25,
            7'd26, 7'd27, 7'd28, 7'd33, 7'd34, 7'd37, 7'd38,
            7'd39, 7'd42, 7'd45:                              n = 6'd1;
            7'd36, 7'd46, 7'd47:                              n = 6'd32;
            7'd40:                                            n = 6'd5;
            7'd41:                                            n = 6'd24;
            default:                                          n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [15:0] mb_to_pixels(input logic [31:0] v);
        logic [32:0] p;
        p = {1'b0, v} + 33'd1;
        return (p > 33'd4095) ? 16'hFFFF : {p[11:0], 4'b0000};
    endfunction

endpackage

>>> rtl/core/sps_if.sv
// Request channels of the SPS parser: NAL byte input and result output.
interface sps_in_if
    import sps_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] nal_byte;
    logic       last_byte;

    modport source (output valid, output nal_byte, output last_byte, input ready);
    modport sink   (input valid, input nal_byte, input last_byte, output ready);
endinterface

interface sps_out_if
    import sps_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  profile;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        frame_mbs_only;
    logic        timing_present;
    logic [31:0] units_in_tick;
    logic [31:0] units_per_sec;

    modport source (output valid, output status, output profile, output frame_width,
                    output frame_height, output frame_mbs_only, output timing_present,
                    output units_in_tick, output units_per_sec, input ready);
    modport sink   (input valid, input status, input profile, input frame_width,
                    input frame_height, input frame_mbs_only, input timing_present,
                    input units_in_tick, input units_per_sec, output ready);
endinterface

>>> rtl/core/sps_front.sv
// Front end: takes NAL bytes, marks emulation-prevention bytes, queues them.
module sps_front
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sps_in_if.sink    i_nal,
    output t_entry    o_q_entry,
    output logic      o_q_valid,
    input  logic      i_q_pop
);

    logic [1:0]   r_zero_run, n_zero_run;
    t_entry       r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0] r_cnt;
    logic         push;
    logic         drop;

    assign i_nal.ready = (r_cnt < (QAW+1)'(QDEPTH));
    assign push        = i_nal.valid && i_nal.ready;
    assign drop        = (r_zero_run == 2'd2) && (i_nal.nal_byte == EPB_BYTE);
    assign o_q_valid   = (r_cnt != '0);
    assign o_q_entry   = r_mem[r_rp];

    always_comb begin
        n_zero_run = r_zero_run;
        if (push) begin
            if (drop)
                n_zero_run = 2'd0;
            else if (i_nal.nal_byte == 8'd0)
                n_zero_run = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
            else
                n_zero_run = 2'd0;
            // each unit starts with a clean zero run
            if (i_nal.last_byte)
                n_zero_run = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wp] <= '{nal_byte: i_nal.nal_byte, last_byte: i_nal.last_byte,
                             drop: drop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            r_zero_run <= n_zero_run;
            if (push)
                r_wp <= r_wp + 1'b1;
            if (i_q_pop)
                r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(i_q_pop);
        end
    end

endmodule

>>> rtl/core/sps_back.sv
// Back end: bit-serial SPS syntax walker with a registered result stage.
module sps_back
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_q_entry,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    sps_out_if.source o_res
);

    logic        r_busy, n_busy;
    t_entry      r_ent;
    logic [2:0]  r_bitcnt, n_bitcnt;
    logic [6:0]  r_step, n_step;
    logic [5:0]  r_zc, n_zc;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_left, n_left;
    logic        r_suf, n_suf;
    logic [31:0] r_loop, n_loop;
    logic [3:0]  r_list, n_list;
    logic [6:0]  r_entry, n_entry;
    logic [7:0]  r_lscale, n_lscale;
    logic [7:0]  r_profile, n_profile;
    logic        r_mbs, n_mbs;
    logic        r_tim, n_tim;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_tick, n_tick;
    logic [31:0] r_tscale, n_tscale;
    logic [1:0]  r_err, n_err;
    logic        r_ov, n_ov;
    t_result     r_res, n_res;

    logic        stall, done_now, finish, emit;
    logic        bitv, fire, go;
    logic [31:0] v;
    logic [6:0]  tgt;
    logic [7:0]  delta8, nscale;
    logic [1:0]  stat;

    assign stall   = r_busy && r_ent.last_byte && r_ov && !o_res.ready;
    assign finish  = r_busy && !stall && done_now;
    assign emit    = finish && r_ent.last_byte;
    assign o_q_pop = i_q_valid && (!r_busy || finish);

    always_comb begin
        n_busy = r_busy; n_bitcnt = r_bitcnt; n_step = r_step; n_zc = r_zc;
        n_acc = r_acc; n_left = r_left; n_suf = r_suf; n_loop = r_loop;
        n_list = r_list; n_entry = r_entry; n_lscale = r_lscale;
        n_profile = r_profile; n_mbs = r_mbs; n_tim = r_tim; n_width = r_width;
        n_height = r_height; n_tick = r_tick; n_tscale = r_tscale; n_err = r_err;
        n_ov = r_ov; n_res = r_res;
        done_now = 1'b1; bitv = 1'b0; fire = 1'b0; go = 1'b0; v = '0;
        tgt = r_step + 7'd1; delta8 = '0; nscale = '0; stat = STAT_OK;

        if (r_busy && !stall) begin
            if (r_ent.drop || r_err != STAT_OK || r_step == ST_DONE) begin
                done_now = 1'b1;
            end else if (r_step == ST_HDR) begin
                if (r_ent.nal_byte[4:0] != NAL_TYPE_SPS)
                    n_err = STAT_NOT_SPS;
                else begin
                    go  = 1'b1;
                    tgt = ST_PROFILE;
                end
            end else begin
                bitv = r_ent.nal_byte[3'd7 - r_bitcnt];
                if (read_bits(r_step) != 6'd0) begin
                    n_acc  = {r_acc[30:0], bitv};
                    n_left = r_left - 6'd1;
                    if (r_left == 6'd1) begin
                        fire = 1'b1;
                        v    = n_acc;
                    end
                end else if (!r_suf) begin
                    if (!bitv) begin
                        if (r_zc >= 6'd31)
                            n_err = STAT_LONG;
                        else
                            n_zc = r_zc + 6'd1;
                    end else if (r_zc == 6'd0) begin
                        fire = 1'b1;
                    end else begin
                        n_suf  = 1'b1;
                        n_left = r_zc;
                        n_acc  = '0;
                    end
                end else begin
                    n_acc  = {r_acc[30:0], bitv};
                    n_left = r_left - 6'd1;
                    if (r_left == 6'd1) begin
                        fire = 1'b1;
                        v    = ((32'd1 << r_zc) - 32'd1) + n_acc;
                    end
                end

                if (fire) begin
                    go = 1'b1;
                    unique case (r_step)
                        ST_PROFILE: n_profile = v[7:0];
                        ST_HIGH:
                            tgt = (r_profile == PROF_HIGH || r_profile == PROF_HIGH10 ||
                                   r_profile == PROF_HIGH422 || r_profile == PROF_HIGH444)
                                  ? ST_CHROMA : ST_LOG2_FRAME;
                        ST_CHROMA: tgt = (v == 32'd3) ? ST_SEP_PLANE : ST_BITDEPTH;
                        ST_SCALE_FLAG: begin
                            n_list = '0;
                            tgt    = (v != 0) ? ST_LIST_FLAG : ST_LOG2_FRAME;
                        end
                        ST_LIST_FLAG: begin
                            if (v != 0) begin
                                n_entry  = '0;
                                n_lscale = SCALE_INIT;
                                tgt      = ST_DELTA;
                            end else begin
                                n_list = r_list + 4'd1;
                                tgt    = (r_list >= 4'd7) ? ST_LOG2_FRAME : ST_LIST_FLAG;
                            end
                        end
                        ST_DELTA: begin
                            // signed mapping, only the low byte matters mod 256
                            delta8  = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
                            nscale  = r_lscale + delta8;
                            n_entry = r_entry + 7'd1;
                            if (nscale != 8'd0)
                                n_lscale = nscale;
                            if (nscale == 8'd0 ||
                                n_entry >= ((r_list < 4'd6) ? 7'd16 : 7'd64)) begin
                                n_list = r_list + 4'd1;
                                tgt    = (r_list >= 4'd7) ? ST_LOG2_FRAME : ST_LIST_FLAG;
                            end else begin
                                tgt = ST_DELTA;
                            end
                        end
                        ST_POC_TYPE:
                            tgt = (v == 32'd0) ? ST_POC_LSB :
                                  (v == 32'd1) ? ST_POC_DZERO : ST_NUM_REF;
                        ST_POC_LSB: tgt = ST_NUM_REF;
                        ST_POC_NREF: begin
                            n_loop = v;
                            tgt    = (v == 32'd0) ? ST_NUM_REF : ST_POC_OFFSET;
                        end
                        ST_POC_OFFSET: begin
                            n_loop = r_loop - 32'd1;
                            tgt    = (r_loop == 32'd1) ? ST_NUM_REF : ST_POC_OFFSET;
                        end
                        ST_WIDTH:  n_width  = mb_to_pixels(v);
                        ST_HEIGHT: n_height = mb_to_pixels(v);
                        ST_MBS_ONLY: begin
                            if (v != 0)
                                n_mbs = 1'b1;
                            tgt = (v != 0) ? ST_DIRECT8 : ST_ADAPT;
                        end
                        ST_CROP:     tgt = (v != 0) ? ST_CROP_L : ST_VUI;
                        ST_VUI:      tgt = (v != 0) ? ST_AR_FLAG : ST_DONE;
                        ST_AR_FLAG:  tgt = (v != 0) ? ST_AR_IDC : ST_OVERSCAN;
                        ST_AR_IDC:   tgt = (v[7:0] == AR_EXTENDED && v[31:8] == '0)
                                           ? ST_SAR : ST_OVERSCAN;
                        ST_OVERSCAN: tgt = (v != 0) ? ST_OVERSCAN_APP : ST_VSIG;
                        ST_VSIG:     tgt = (v != 0) ? ST_VFMT : ST_CHROMA_LOC;
                        ST_VFMT:     tgt = v[0] ? ST_COLOR : ST_CHROMA_LOC;
                        ST_CHROMA_LOC: tgt = (v != 0) ? ST_CHROMA_TOP : ST_TIMING;
                        ST_TIMING: begin
                            if (v != 0)
                                n_tim = 1'b1;
                            tgt = (v != 0) ? ST_TICK : ST_DONE;
                        end
                        ST_TICK:   n_tick = v;
                        ST_TSCALE: begin
                            n_tscale = v;
                            tgt      = ST_DONE;
                        end
                        default: ;
                    endcase
                end
                n_bitcnt = r_bitcnt + 3'd1;
            end

            if (go) begin
                n_step = (tgt > ST_DONE) ? ST_DONE : tgt;
                n_acc  = '0;
                n_zc   = '0;
                n_suf  = 1'b0;
                n_left = read_bits(n_step);
            end

            if (!(r_ent.drop || r_err != STAT_OK || r_step == ST_DONE ||
                  r_step == ST_HDR))
                done_now = (r_bitcnt == 3'd7) || (n_err != STAT_OK) || (n_step == ST_DONE);
        end

        if (r_ov && o_res.ready)
            n_ov = 1'b0;

        if (emit) begin
            stat = (n_err != STAT_OK) ? n_err : ((n_step == ST_DONE) ? STAT_OK : STAT_EARLY);
            n_ov = 1'b1;
            if (stat == STAT_OK)
                n_res = '{status: STAT_OK, profile: n_profile, frame_width: n_width,
                          frame_height: n_height, frame_mbs_only: n_mbs,
                          timing_present: n_tim, units_in_tick: n_tick,
                          units_per_sec: n_tscale};
            else
                n_res = '{status: stat, default: '0};
            // back to the header-byte state for the next unit
            n_step = ST_HDR; n_zc = '0; n_acc = '0; n_left = '0; n_suf = 1'b0;
            n_loop = '0; n_list = '0; n_entry = '0; n_lscale = SCALE_INIT;
            n_profile = '0; n_mbs = 1'b0; n_tim = 1'b0; n_width = '0; n_height = '0;
            n_tick = '0; n_tscale = '0; n_err = STAT_OK;
        end

        if (o_q_pop) begin
            n_busy   = 1'b1;
            n_bitcnt = '0;
        end else if (finish) begin
            n_busy   = 1'b0;
            n_bitcnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop)
            r_ent <= i_q_entry;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_bitcnt <= '0; r_step <= ST_HDR; r_zc <= '0;
            r_acc <= '0; r_left <= '0; r_suf <= 1'b0; r_loop <= '0; r_list <= '0;
            r_entry <= '0; r_lscale <= SCALE_INIT; r_profile <= '0; r_mbs <= 1'b0;
            r_tim <= 1'b0; r_width <= '0; r_height <= '0; r_tick <= '0;
            r_tscale <= '0; r_err <= STAT_OK; r_ov <= 1'b0;
        end else begin
            r_busy <= n_busy; r_bitcnt <= n_bitcnt; r_step <= n_step; r_zc <= n_zc;
            r_acc <= n_acc; r_left <= n_left; r_suf <= n_suf; r_loop <= n_loop;
            r_list <= n_list; r_entry <= n_entry; r_lscale <= n_lscale;
            r_profile <= n_profile; r_mbs <= n_mbs; r_tim <= n_tim;
            r_width <= n_width; r_height <= n_height; r_tick <= n_tick;
            r_tscale <= n_tscale; r_err <= n_err; r_ov <= n_ov;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.status         = r_res.status;
    assign o_res.profile        = r_res.profile;
    assign o_res.frame_width    = r_res.frame_width;
    assign o_res.frame_height   = r_res.frame_height;
    assign o_res.frame_mbs_only = r_res.frame_mbs_only;
    assign o_res.timing_present = r_res.timing_present;
    assign o_res.units_in_tick  = r_res.units_in_tick;
    assign o_res.units_per_sec  = r_res.units_per_sec;

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid) else $error("queue popped while empty");

    a_emit_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_step == ST_HDR && r_err == STAT_OK && r_ov))
        else $error("parser state not cleared after result");

    a_bitcnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bitcnt != 3'd0) |-> r_busy) else $error("bit counter runs while idle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.status != STAT_OK) |->
            (r_res.profile == '0 && r_res.frame_width == '0 && r_res.units_per_sec == '0))
        else $error("error result carries field data");

endmodule

>>> rtl/core/h264_sps_header_parser_top.sv
// Each accepted byte is queued and moves into the parser when the parser pops it; a 4-entry
// queue lets input continue while the parser is busy. A parsed byte is walked one SPS bit per
// cycle while no earlier result waits to be taken; header, dropped 0x03 and ignored bytes are
// not walked bit by bit. Synchronous active-low reset clears all control state.
module h264_sps_header_parser_top
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    sps_in_if.sink    i_nal,
    sps_out_if.source o_res
);

    t_entry q_entry;
    logic   q_valid;
    logic   q_pop;

    sps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_nal     (i_nal),
        .o_q_entry (q_entry),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop)
    );

    sps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_entry (q_entry),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

>>> test/tb_top.sv
// Self-checking testbench of the SPS header parser: SPS units, errors and stalls.
module tb_top;
    import sps_pkg::*;

    logic i_clk;
    logic i_rst_n;

    sps_in_if  nal_if ();
    sps_out_if res_if ();

    h264_sps_header_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nal   (nal_if),
        .o_res   (res_if)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // ---------------- parser shadow state ----------------
    localparam logic [5:0] FIELD_LEN [49] = '{
        0, 8, 8, 8, 0, 0, 1, 0, 0, 1,
        1, 1, 0, 0, 0, 0, 1, 0, 0, 0,
        0, 0, 1, 0, 0, 1, 1, 1, 1, 0,
        0, 0, 0, 1, 1, 8, 32, 1, 1, 1,
        5, 24, 1, 0, 0, 1, 32, 32, 0
    };

    logic [1:0]  zrun;
    logic [6:0]  step;
    logic [5:0]  ug_zeros;
    logic [31:0] ug_acc;
    logic [5:0]  bits_left;
    logic [31:0] offs_left;
    logic [3:0]  list_no;
    logic [6:0]  entry_no;
    logic [7:0]  prev_scale;
    logic [7:0]  cur_scale;
    logic [7:0]  prof_q;
    logic [31:0] poc_type;
    logic        mbs_only_q;
    logic        timing_q;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [31:0] tick_q;
    logic [31:0] tscale_q;
    logic [1:0]  err_q;
    logic        ug_suffix;

    t_result sps_expected [$];

    function automatic void parser_clear();
        zrun = 0; step = ST_HDR; ug_zeros = 0; ug_acc = 0; bits_left = 0;
        offs_left = 0; list_no = 0; entry_no = 0; prev_scale = SCALE_INIT;
        cur_scale = SCALE_INIT; prof_q = 0; poc_type = 0; mbs_only_q = 0;
        timing_q = 0; width_q = 0; height_q = 0; tick_q = 0; tscale_q = 0;
        err_q = STAT_OK; ug_suffix = 0;
    endfunction

    function automatic void goto_step(input logic [6:0] s);
        if (s > ST_DONE) s = ST_DONE;
        step = s;
        ug_acc = 0;
        ug_zeros = 0;
        ug_suffix = 0;
        bits_left = FIELD_LEN[s];
    endfunction

    function automatic logic [15:0] to_pixels(input logic [31:0] v);
        longint unsigned p;
        p = (longint'(v) + 1) * 16;
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic void advance_list();
        list_no++;
        goto_step(list_no >= 8 ? ST_LOG2_FRAME : ST_LIST_FLAG);
    endfunction

    function automatic void take_value(input logic [31:0] v);
        logic [31:0] delta;
        case (step)
            ST_PROFILE: begin prof_q = v[7:0]; goto_step(step + 7'd1); end
            ST_HIGH: begin
                if (prof_q inside {PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444})
                    goto_step(ST_CHROMA);
                else
                    goto_step(ST_LOG2_FRAME);
            end
            ST_CHROMA:    goto_step(v == 3 ? ST_SEP_PLANE : ST_BITDEPTH);
            ST_SCALE_FLAG: begin
                if (v != 0) begin list_no = 0; goto_step(ST_LIST_FLAG); end
                else goto_step(ST_LOG2_FRAME);
            end
            ST_LIST_FLAG: begin
                if (v != 0) begin
                    entry_no = 0; prev_scale = SCALE_INIT; cur_scale = SCALE_INIT;
                    goto_step(ST_DELTA);
                end else advance_list();
            end
            ST_DELTA: begin
                delta = v[0] ? (v >> 1) + 1 : 32'd0 - (v >> 1);
                cur_scale = prev_scale + delta[7:0];
                if (cur_scale != 0) prev_scale = cur_scale;
                entry_no++;
                if (cur_scale == 0 || entry_no >= (list_no < 6 ? 16 : 64)) advance_list();
                else goto_step(ST_DELTA);
            end
            ST_POC_TYPE: begin
                poc_type = v;
                if (v == 0) goto_step(ST_POC_LSB);
                else if (v == 1) goto_step(ST_POC_DZERO);
                else goto_step(ST_NUM_REF);
            end
            ST_POC_LSB:   goto_step(ST_NUM_REF);
            ST_POC_NREF: begin
                offs_left = v;
                goto_step(v == 0 ? ST_NUM_REF : ST_POC_OFFSET);
            end
            ST_POC_OFFSET: begin
                offs_left--;
                goto_step(offs_left == 0 ? ST_NUM_REF : ST_POC_OFFSET);
            end
            ST_WIDTH:  begin width_q = to_pixels(v); goto_step(ST_HEIGHT); end
            ST_HEIGHT: begin height_q = to_pixels(v); goto_step(ST_MBS_ONLY); end
            ST_MBS_ONLY: begin
                if (v != 0) mbs_only_q = 1;
                goto_step(v != 0 ? ST_DIRECT8 : ST_ADAPT);
            end
            ST_CROP:     goto_step(v != 0 ? ST_CROP_L : ST_VUI);
            ST_VUI:      goto_step(v != 0 ? ST_AR_FLAG : ST_DONE);
            ST_AR_FLAG:  goto_step(v != 0 ? ST_AR_IDC : ST_OVERSCAN);
            ST_AR_IDC:   goto_step(v == AR_EXTENDED ? ST_SAR : ST_OVERSCAN);
            ST_OVERSCAN: goto_step(v != 0 ? ST_OVERSCAN_APP : ST_VSIG);
            ST_VSIG:     goto_step(v != 0 ? ST_VFMT : ST_CHROMA_LOC);
            ST_VFMT:     goto_step(v[0] ? ST_COLOR : ST_CHROMA_LOC);
            ST_CHROMA_LOC: goto_step(v != 0 ? ST_CHROMA_TOP : ST_TIMING);
            ST_TIMING: begin
                if (v != 0) timing_q = 1;
                goto_step(v != 0 ? ST_TICK : ST_DONE);
            end
            ST_TICK:   begin tick_q = v; goto_step(ST_TSCALE); end
            ST_TSCALE: begin tscale_q = v; goto_step(ST_DONE); end
            default:   goto_step(step + 7'd1);
        endcase
    endfunction

    function automatic void shift_bit(input logic b);
        logic [31:0] base;
        if (FIELD_LEN[step] != 0) begin
            ug_acc = {ug_acc[30:0], b};
            bits_left--;
            if (bits_left == 0) take_value(ug_acc);
        end else if (!ug_suffix) begin
            if (!b) begin
                if (ug_zeros >= 31) err_q = STAT_LONG;
                else ug_zeros++;
            end else if (ug_zeros == 0) begin
                take_value(0);
            end else begin
                ug_suffix = 1;
                bits_left = ug_zeros;
                ug_acc = 0;
            end
        end else begin
            ug_acc = {ug_acc[30:0], b};
            bits_left--;
            if (bits_left == 0) begin
                base = (32'd1 << ug_zeros) - 1;
                take_value(base + ug_acc);
            end
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic is_last);
        t_result r;
        if (zrun >= 2 && b == EPB_BYTE) begin
            zrun = 0;
        end else begin
            if (b == 0) zrun = (zrun >= 2) ? 2'd2 : zrun + 1;
            else zrun = 0;
            if (err_q == STAT_OK) begin
                if (step == ST_HDR) begin
                    if (b[4:0] != NAL_TYPE_SPS) err_q = STAT_NOT_SPS;
                    else goto_step(ST_PROFILE);
                end else begin
                    for (int i = 7; i >= 0; i--)
                        if (err_q == STAT_OK && step != ST_DONE) shift_bit(b[i]);
                end
            end
        end
        if (is_last) begin
            r = '0;
            r.status = (err_q != STAT_OK) ? err_q : (step == ST_DONE ? STAT_OK : STAT_EARLY);
            if (r.status == STAT_OK) begin
                r.profile = prof_q; r.frame_width = width_q; r.frame_height = height_q;
                r.frame_mbs_only = mbs_only_q; r.timing_present = timing_q;
                r.units_in_tick = tick_q; r.units_per_sec = tscale_q;
            end
            sps_expected.push_back(r);
            parser_clear();
        end
    endfunction

    // ---------------- unit builder ----------------
    bit          rbsp_bits [$];
    logic [7:0]  unit_bytes [$];

    function automatic void put_bits(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) rbsp_bits.push_back(v[i]);
    endfunction

    function automatic void put_ue(input longint unsigned v);
        longint unsigned x;
        int n;
        x = v + 1;
        n = 0;
        while ((x >> n) > 1) n++;
        put_bits(0, n);
        put_bits(x, n + 1);
    endfunction

    function automatic void put_se(input int v);
        put_ue(v > 0 ? 2 * longint'(v) - 1 : -2 * longint'(v));
    endfunction

    function automatic longint unsigned rand_ue();
        case ($urandom_range(0, 9))
            0, 1, 2: return 0;
            3, 4, 5, 6: return $urandom_range(1, 20);
            7: return $urandom_range(21, 5000);
            8: return $urandom_range(0, 32'hFFFF_FFFE);
            default: return 32'hFFFF_FFFE;
        endcase
    endfunction

    // pack rbsp bits, a stop bit and extra random bytes into bytes with emulation escapes, behind a header byte
    function automatic void pack_unit(input logic [7:0] hdr, input int extra);
        logic [7:0] b;
        int zr;
        unit_bytes.delete();
        unit_bytes.push_back(hdr);
        rbsp_bits.push_back(1);
        while (rbsp_bits.size() % 8 != 0) rbsp_bits.push_back(0);
        repeat (extra * 8) rbsp_bits.push_back($urandom_range(0, 1));
        zr = 0;
        while (rbsp_bits.size() > 0) begin
            for (int i = 7; i >= 0; i--) b[i] = rbsp_bits.pop_front();
            if (zr >= 2 && b <= 8'h03) begin
                unit_bytes.push_back(EPB_BYTE);
                zr = 0;
            end
            unit_bytes.push_back(b);
            zr = (b == 0) ? zr + 1 : 0;
        end
    endfunction

    function automatic logic [7:0] sps_hdr();
        return {$urandom_range(0, 1) == 0 ? 1'b0 : 1'b1, 2'($urandom), NAL_TYPE_SPS};
    endfunction

    // random SPS syntax; the force_all knob forces the rarer branches
    function automatic void build_sps(input bit force_all);
        logic [7:0] prof;
        longint unsigned v;
        int cnt;
        bit hi;
        rbsp_bits.delete();
        case ($urandom_range(0, 5))
            0: prof = PROF_HIGH;
            1: prof = PROF_HIGH10;
            2: prof = PROF_HIGH422;
            3: prof = PROF_HIGH444;
            default: prof = 8'($urandom);
        endcase
        if (force_all) prof = PROF_HIGH;
        hi = prof inside {PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444};
        put_bits(prof, 8);
        put_bits($urandom, 16);
        put_ue(rand_ue());
        if (hi) begin
            v = $urandom_range(0, 3);
            put_ue(v);
            if (v == 3) put_bits($urandom_range(0, 1), 1);
            put_ue(rand_ue()); put_ue(rand_ue());
            put_bits($urandom_range(0, 1), 1);
            if (force_all || $urandom_range(0, 2) == 0) begin
                put_bits(1, 1);
                for (int l = 0; l < 8; l++) begin
                    if (force_all || $urandom_range(0, 1)) begin
                        put_bits(1, 1);
                        cnt = (l < 6) ? 16 : 64;
                        for (int e = 0; e < cnt; e++) begin
                            case ($urandom_range(0, 19))
                                0: begin put_se(-8); break; end
                                1: put_se(int'($urandom_range(0, 255)) - 128);
                                2: put_se(int'($urandom) >>> 4);
                                default: put_se(int'($urandom_range(0, 6)) - 3);
                            endcase
                        end
                    end else put_bits(0, 1);
                end
            end else put_bits(0, 1);
        end
        put_ue(rand_ue());
        v = force_all ? 1 : $urandom_range(0, 3);
        put_ue(v);
        if (v == 0) put_ue(rand_ue());
        else if (v == 1) begin
            put_bits($urandom_range(0, 1), 1);
            put_se(int'($urandom_range(0, 200)) - 100);
            put_se(int'($urandom_range(0, 200)) - 100);
            cnt = $urandom_range(0, 5);
            put_ue(cnt);
            repeat (cnt) put_se(int'($urandom_range(0, 40)) - 20);
        end
        put_ue(rand_ue());
        put_bits($urandom_range(0, 1), 1);
        put_ue(rand_ue()); put_ue(rand_ue());
        v = $urandom_range(0, 1);
        put_bits(v, 1);
        if (v == 0) put_bits($urandom_range(0, 1), 1);
        put_bits($urandom_range(0, 1), 1);
        if (force_all || $urandom_range(0, 1)) begin
            put_bits(1, 1);
            repeat (4) put_ue(rand_ue());
        end else put_bits(0, 1);
        if (force_all || $urandom_range(0, 3) != 0) begin
            put_bits(1, 1);
            if (force_all || $urandom_range(0, 1)) begin
                put_bits(1, 1);
                v = (force_all || $urandom_range(0, 1)) ? AR_EXTENDED : $urandom_range(0, 254);
                put_bits(v, 8);
                if (v == AR_EXTENDED) put_bits($urandom, 32);
            end else put_bits(0, 1);
            if (force_all || $urandom_range(0, 1)) begin
                put_bits(1, 1); put_bits($urandom_range(0, 1), 1);
            end else put_bits(0, 1);
            if (force_all || $urandom_range(0, 1)) begin
                put_bits(1, 1);
                v = $urandom_range(0, 31);
                if (force_all) v[0] = 1;
                put_bits(v, 5);
                if (v[0]) put_bits($urandom, 24);
            end else put_bits(0, 1);
            if (force_all || $urandom_range(0, 1)) begin
                put_bits(1, 1); put_ue(rand_ue()); put_ue(rand_ue());
            end else put_bits(0, 1);
            if (force_all || $urandom_range(0, 3) != 0) begin
                put_bits(1, 1);
                put_bits($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom, 32);
                put_bits($urandom_range(0, 3) == 0 ? 32'h0 : $urandom, 32);
            end else put_bits(0, 1);
        end else put_bits(0, 1);
    endfunction

    // ---------------- request driving ----------------
    bit idle_on;
    int bytes_sent;
    int units_sent;
    int hold_req;

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            nal_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        nal_if.valid     <= 1'b1;
        nal_if.nal_byte  <= b;
        nal_if.last_byte <= is_last;
        @(posedge i_clk);
        while (!nal_if.ready) @(posedge i_clk);
        predict_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_unit();
        for (int i = 0; i < unit_bytes.size(); i++)
            send_byte(unit_bytes[i], i == unit_bytes.size() - 1);
        units_sent++;
    endtask

    // one random unit: mostly complete SPS, some cut short, some noise, some with a random NAL type
    task automatic send_random_unit();
        int k;
        k = $urandom_range(0, 19);
        build_sps(0);
        pack_unit(sps_hdr(), $urandom_range(0, 3));
        if (k < 3) begin
            while (unit_bytes.size() > 1 && $urandom_range(0, 3) != 0)
                void'(unit_bytes.pop_back());
        end else if (k < 5) begin
            unit_bytes.delete();
            repeat ($urandom_range(1, 30))
                unit_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
        end else if (k == 5) begin
            unit_bytes[0][4:0] = 5'($urandom_range(0, 31));
        end
        send_unit();
    endtask

    // ---------------- result checking ----------------
    int errors;
    int results_seen;
    int stall_left;
    int status_hits [4];

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else if (hold_req > 0) begin
            res_if.ready <= 1'b0;
            hold_req--;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (sps_expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result, status %0d", res_if.status);
            end else begin
                e = sps_expected.pop_front();
                status_hits[e.status]++;
                if (res_if.status !== e.status || res_if.profile !== e.profile ||
                    res_if.frame_width !== e.frame_width ||
                    res_if.frame_height !== e.frame_height ||
                    res_if.frame_mbs_only !== e.frame_mbs_only ||
                    res_if.timing_present !== e.timing_present ||
                    res_if.units_in_tick !== e.units_in_tick ||
                    res_if.units_per_sec !== e.units_per_sec) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch exp st=%0d prof=%0d w=%0d h=%0d fmo=%0b tp=%0b t=%0h s=%0h",
                                 e.status, e.profile, e.frame_width, e.frame_height,
                                 e.frame_mbs_only, e.timing_present, e.units_in_tick,
                                 e.units_per_sec);
                        $display("         got st=%0d prof=%0d w=%0d h=%0d fmo=%0b tp=%0b t=%0h s=%0h",
                                 res_if.status, res_if.profile, res_if.frame_width,
                                 res_if.frame_height, res_if.frame_mbs_only,
                                 res_if.timing_present, res_if.units_in_tick,
                                 res_if.units_per_sec);
                    end
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        // complete high-profile SPS with the scaling-list, POC type 1, crop and VUI branches forced
        build_sps(1);
        pack_unit(8'h67, 0);
        send_unit();
        // baseline profile, minimal syntax, max-size ue for width
        rbsp_bits.delete();
        put_bits(8'd66, 8); put_bits(16'h00FF, 16); put_ue(0);
        put_ue(0); put_ue(2); put_ue(0); put_bits(0, 1);
        put_ue(32'hFFFF_FFFE); put_ue(4095); put_bits(1, 1); put_bits(0, 1);
        put_bits(0, 1); put_bits(0, 1);
        pack_unit(8'hE7, 2);
        send_unit();
        // header of another NAL type, then ignored bytes
        unit_bytes = '{8'h68, 8'hFF, 8'h00, 8'h00, 8'h03};
        send_unit();
        // SPS header alone
        unit_bytes = '{8'h67};
        send_unit();
        // 40 leading zeros in one code, with escapes along the way
        unit_bytes = '{8'h67, 8'h42, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00,
                       8'h03, 8'h00, 8'h80};
        send_unit();
        // cut off in the middle of the syntax
        build_sps(1);
        pack_unit(8'h27, 0);
        unit_bytes = unit_bytes[0:5];
        send_unit();
    endtask

    task automatic test_random();
        while (bytes_sent < 700) send_random_unit();
    endtask

    task automatic test_backpressure();
        nal_if.valid <= 1'b0;
        wait (sps_expected.size() == 0);
        hold_req = 400;
        repeat (4) send_random_unit();
    endtask

    task automatic test_full_rate();
        idle_on = 0;
        while (bytes_sent < 1050) send_random_unit();
        nal_if.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        nal_if.valid = 1'b0;
        nal_if.nal_byte = '0;
        nal_if.last_byte = 1'b0;
        res_if.ready = 1'b0;
        idle_on = 1;
        hold_req = 0;
        parser_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_full_rate();
        wait (sps_expected.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d bytes in %0d NAL units; %0d results checked", bytes_sent,
                 units_sent, results_seen);
        $display("status ok/not-sps/early/long-code: %0d/%0d/%0d/%0d", status_hits[0],
                 status_hits[1], status_hits[2], status_hits[3]);
        if (errors == 0 && sps_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout: %0d results outstanding", sps_expected.size());
        $display("FAIL");
        $finish;
    end

endmodule

>>> h264_sps_header_parser_top.f
rtl/core/sps_pkg.sv
rtl/core/sps_if.sv
rtl/core/sps_front.sv
rtl/core/sps_back.sv
rtl/core/h264_sps_header_parser_top.sv
test/tb_top.sv
